// ===== sv/qmetm_pkg.sv =====
// Package for the quad mesh edge twin matcher: item types and sequencer states.
// Depends on nothing; every other file takes its names by scope.
`default_nettype none

package qmetm_pkg;

  // One quad item: a mode bit and four corner vertex ids
  typedef struct packed {
    logic        mode;
    logic [15:0] corner_0;
    logic [15:0] corner_1;
    logic [15:0] corner_2;
    logic [15:0] corner_3;
  } quad_item_t;

  // One dart result item
  typedef struct packed {
    logic [13:0] dart_index;
    logic [15:0] start_vertex;
    logic [13:0] edge_number;
    logic        has_twin;
    logic [13:0] twin_dart;
    logic        table_overflow;
    logic [14:0] edge_total;
    logic        last;
  } dart_item_t;

  // Mode codes
  localparam logic MODE_QUAD  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Darts of one quad and the id space of darts and edges
  localparam int QUAD_DARTS = 4;
  localparam int ID_CAP     = 16384;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ISSUE,
    ST_PROBE
  } seq_state_t;

endpackage

`default_nettype wire

// ===== sv/quad_mesh_edge_twin_matcher.sv =====
// Quad mesh edge twin matcher: hashed edge table with linear probing, one write
// and one read memory port under a small sequencer. Depends on qmetm_pkg.
`default_nettype none

//  channel | signals                            | accepted when
//  --------+------------------------------------+----------------------------
//  quad    | quad_valid, quad_ready, quad_item  | quad_valid && quad_ready
//  dart    | dart_valid, dart_ready, dart_item  | dart_valid && dart_ready
//
//  A quad item is accepted in ST_IDLE, then per dart the key is hashed and the
//  start slot read in ST_ISSUE, and ST_PROBE compares one table slot per probe;
//  the pace is set by the single read port of the edge memory.
//  After reset and after a clear item a sweep empties the table slot by slot,
//  during which quad_ready is low.
//  A dart waits in the output register; the next probe goes on meanwhile and
//  only the hand-over of a finished dart stalls on dart_ready.

module quad_mesh_edge_twin_matcher #(
  parameter int TABLE_DEPTH = 4096,
  parameter int MAX_QUADS   = 4096,
  parameter int VERTEX_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   quad_valid,
  output logic                  quad_ready,
  input  qmetm_pkg::quad_item_t quad_item,
  output logic                  dart_valid,
  input  wire                   dart_ready,
  output qmetm_pkg::dart_item_t dart_item
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int QW  = $clog2(MAX_QUADS + 1);
  localparam int VW  = (VERTEX_BITS < 16) ? VERTEX_BITS : 16;
  localparam int KW  = 2 * VW;
  localparam int NCH = (KW + IW - 1) / IW;
  localparam int CAP = (TABLE_DEPTH < qmetm_pkg::ID_CAP) ? TABLE_DEPTH : qmetm_pkg::ID_CAP;
  localparam int EW  = 1 + 2 * VW + 28;

  // Entry layout: {valid, lo, hi, dart, edge}
  localparam int E_DART = 14;
  localparam int E_HI   = 28;
  localparam int E_LO   = 28 + VW;
  localparam int E_VAL  = EW - 1;

  // Fold the key into a start slot below TABLE_DEPTH
  function automatic logic [IW-1:0] hash_key(input logic [VW-1:0] lo,
                                             input logic [VW-1:0] hi);
    logic [NCH*IW-1:0] pad;
    logic [IW-1:0]     h;
    logic [IW:0]       hx;
    pad = (NCH*IW)'({hi, lo});
    h   = '0;
    for (int i = 0; i < NCH; i++) begin
      h = h ^ pad[i*IW +: IW];
    end
    hx = {1'b0, h};
    if (hx >= (IW+1)'(TABLE_DEPTH)) begin
      hx = hx - (IW+1)'(TABLE_DEPTH);
    end
    return hx[IW-1:0];
  endfunction

  qmetm_pkg::seq_state_t state, state_next;

  logic [IW-1:0] cnt;
  logic [IW-1:0] probe_idx;
  logic [1:0]    k;
  logic [QW-1:0] quad_counter;
  logic [14:0]   edge_counter;
  logic [VW-1:0] corner_v [4];
  logic [VW-1:0] key_lo, key_hi, start_v;
  logic [EW-1:0] rd_data;
  logic [EW-1:0] edge_mem [TABLE_DEPTH];

  // Combinational control
  logic          quad_acc;
  logic          rd_en, wr_en, out_load, insert, hit, empty, exhausted, resolve, slot_free;
  logic [IW-1:0] rd_addr, wr_addr, nxt_idx, start_idx;
  logic [EW-1:0] wr_data;
  logic [VW-1:0] va, vb, lo_c, hi_c;
  logic [1:0]    k_p1;
  logic [13:0]   dart_num;
  qmetm_pkg::dart_item_t dart_next;

  // Key of the current dart
  always_comb begin
    k_p1      = k + 2'd1;
    va        = corner_v[k];
    vb        = corner_v[k_p1];
    lo_c      = (va < vb) ? va : vb;
    hi_c      = (va < vb) ? vb : va;
    start_idx = hash_key(lo_c, hi_c);
    nxt_idx   = (probe_idx == IW'(TABLE_DEPTH - 1)) ? '0 : probe_idx + 1'b1;
    dart_num  = 14'({quad_counter, k});
  end

  // Probe outcome
  always_comb begin
    hit       = rd_data[E_VAL] && (rd_data[E_LO +: VW] == key_lo) &&
                (rd_data[E_HI +: VW] == key_hi);
    empty     = !rd_data[E_VAL];
    exhausted = (cnt == IW'(TABLE_DEPTH - 1));
    resolve   = hit || empty || exhausted;
    insert    = empty && (edge_counter < 15'(CAP));
    slot_free = !dart_valid || dart_ready;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      qmetm_pkg::ST_IDLE: begin
        if (quad_valid) begin
          if (quad_item.mode == qmetm_pkg::MODE_CLEAR) begin
            state_next = qmetm_pkg::ST_CLEAR;
          end else if (quad_counter < QW'(MAX_QUADS)) begin
            state_next = qmetm_pkg::ST_ISSUE;
          end
        end
      end
      qmetm_pkg::ST_CLEAR: begin
        if (cnt == IW'(TABLE_DEPTH - 1)) state_next = qmetm_pkg::ST_IDLE;
      end
      qmetm_pkg::ST_ISSUE: begin
        state_next = qmetm_pkg::ST_PROBE;
      end
      qmetm_pkg::ST_PROBE: begin
        if (resolve && slot_free) begin
          state_next = (k == 2'd3) ? qmetm_pkg::ST_IDLE : qmetm_pkg::ST_ISSUE;
        end
      end
      default: state_next = qmetm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    quad_ready = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = start_idx;
    wr_en      = 1'b0;
    wr_addr    = probe_idx;
    wr_data    = '0;
    out_load   = 1'b0;
    case (state)
      qmetm_pkg::ST_IDLE: begin
        quad_ready = 1'b1;
      end
      qmetm_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt;
      end
      qmetm_pkg::ST_ISSUE: begin
        rd_en = 1'b1;
      end
      qmetm_pkg::ST_PROBE: begin
        if (!resolve) begin
          rd_en   = 1'b1;
          rd_addr = nxt_idx;
        end else if (slot_free) begin
          out_load = 1'b1;
          wr_en    = insert;
          wr_data  = {1'b1, key_lo, key_hi, dart_num, edge_counter[13:0]};
        end
      end
      default: ;
    endcase
    quad_acc = quad_valid && quad_ready;
  end

  // Form the dart result
  always_comb begin
    dart_next.dart_index     = dart_num;
    dart_next.start_vertex   = 16'(start_v);
    dart_next.edge_number    = hit ? rd_data[13:0] : (insert ? edge_counter[13:0] : 14'd0);
    dart_next.has_twin       = hit;
    dart_next.twin_dart      = hit ? rd_data[E_DART +: 14] : 14'd0;
    dart_next.table_overflow = !hit && !insert;
    dart_next.edge_total     = insert ? edge_counter + 15'd1 : edge_counter;
    dart_next.last           = (k == 2'd3);
  end

  // Edge memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) edge_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= edge_mem[rd_addr];
  end

  // Hold the quad corners and the current key
  always_ff @(posedge clk) begin
    if (quad_acc) begin
      corner_v[0] <= quad_item.corner_0[VW-1:0];
      corner_v[1] <= quad_item.corner_1[VW-1:0];
      corner_v[2] <= quad_item.corner_2[VW-1:0];
      corner_v[3] <= quad_item.corner_3[VW-1:0];
    end
    if (state == qmetm_pkg::ST_ISSUE) begin
      key_lo  <= lo_c;
      key_hi  <= hi_c;
      start_v <= va;
    end
    if (out_load) dart_item <= dart_next;
  end

  // Advance the sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= qmetm_pkg::ST_CLEAR;
      cnt          <= '0;
      probe_idx    <= '0;
      k            <= '0;
      quad_counter <= '0;
      edge_counter <= '0;
      dart_valid   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        qmetm_pkg::ST_IDLE: begin
          k   <= '0;
          cnt <= '0;
          if (quad_valid && quad_item.mode == qmetm_pkg::MODE_CLEAR) begin
            quad_counter <= '0;
            edge_counter <= '0;
          end
        end
        qmetm_pkg::ST_CLEAR: begin
          cnt <= cnt + 1'b1;
        end
        qmetm_pkg::ST_ISSUE: begin
          probe_idx <= start_idx;
          cnt       <= '0;
        end
        qmetm_pkg::ST_PROBE: begin
          if (!resolve) begin
            probe_idx <= nxt_idx;
            cnt       <= cnt + 1'b1;
          end else if (slot_free) begin
            k <= k_p1;
            if (insert) edge_counter <= edge_counter + 15'd1;
            if (k == 2'd3) quad_counter <= quad_counter + 1'b1;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        dart_valid <= 1'b1;
      end else if (dart_ready) begin
        dart_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_edge_cap: assert property (@(posedge clk) disable iff (rst)
    edge_counter <= 15'(CAP))
    else $error("edge counter beyond table capacity");

  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    (state == qmetm_pkg::ST_PROBE && wr_en) |-> !rd_data[E_VAL])
    else $error("insert into an occupied slot");

  a_twin_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (dart_valid && dart_item.has_twin) |-> !dart_item.table_overflow)
    else $error("dart both paired and overflowed");

  a_quad_count: assert property (@(posedge clk) disable iff (rst)
    (out_load && k == 2'd3) |=> quad_counter == QW'($past(quad_counter) + 1'b1))
    else $error("quad counter not advanced after last dart");

endmodule

`default_nettype wire
